>>> src/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PPU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/ppu_pkg.sv
// Shared types, constants and codes for the packed product unpacker.
// No dependencies.
package ppu_pkg;

    localparam int COEFF_W    = 50;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 8;
    localparam int MOD_W      = 5;
    localparam int DIGIT_W    = 17;
    localparam int CARRY_W    = 18;
    localparam int SUM_W      = 19;
    localparam int DIV_W      = 20;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int DEF_MAX_MODULUS = 23;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 5'd2;
    localparam logic DIGIT_MODE_RESET = 1'b0;

    localparam logic REG_MODULUS    = 1'b0;
    localparam logic REG_DIGIT_MODE = 1'b1;

    localparam logic [1:0] FUNC_PAIR  = 2'd0;
    localparam logic [1:0] FUNC_LOW   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]   v0;
        logic [DIGIT_W-1:0] v1;
        logic               pair;
        logic               eop;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_WAIT
    } bk_state_t;

endpackage

>>> src/ppu_front.sv
// Front end: accepts input transfers, splits digits, tracks the carry digit.
// Depends on ppu_pkg.
module ppu_front import ppu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 digit_mode,
    input  logic                 fifo_full,
    output logic                 push,
    output job_t                 job
);

    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [COEFF_W-1:0] coeff;
    logic [DIGIT_W-1:0] c0, c1;
    logic [CARRY_W-1:0] c2;
    logic               accept;

    assign coeff    = s_tdata[COEFF_W-1:0];
    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (digit_mode) begin
            c0 = coeff[16:0];
            c1 = coeff[33:17];
            c2 = {2'b00, coeff[49:34]};
        end else begin
            c0 = {1'b0, coeff[15:0]};
            c1 = {1'b0, coeff[31:16]};
            c2 = coeff[49:32];
        end
    end

    always_comb begin
        push       = 1'b0;
        carry_next = carry_reg;
        job.v0     = SUM_W'(c0) + SUM_W'(carry_reg);
        job.v1     = c1;
        job.pair   = 1'b0;
        job.eop    = 1'b1;
        case (s_tuser)
            FUNC_PAIR: begin
                push       = accept;
                job.pair   = 1'b1;
                job.eop    = s_tlast;
                carry_next = s_tlast ? '0 : c2;
            end
            FUNC_LOW: begin
                push       = accept;
                carry_next = '0;
            end
            FUNC_FLUSH: begin
                push       = accept;
                job.v0     = SUM_W'(carry_reg);
                carry_next = '0;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
        end else if (accept) begin
            carry_reg <= carry_next;
        end
    end

endmodule

>>> src/ppu_fifo.sv
// Two-entry job queue between front end and back end.
// Depends on ppu_pkg.
module ppu_fifo import ppu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/ppu_back.sv
// Back end: iterative remainder unit, 4 bits per cycle, and output register.
// Depends on ppu_pkg.
module ppu_back import ppu_pkg::*; #(
    parameter int MAX_MODULUS = DEF_MAX_MODULUS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MOD_W-1:0]     modulus,
    input  logic                 fifo_empty,
    input  job_t                 job,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam logic [MOD_W-1:0] MaxMod = MOD_W'(MAX_MODULUS);

    bk_state_t          state_reg, state_next;
    logic [DIV_W-1:0]   work_reg, work_next;
    logic [MOD_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DIGIT_W-1:0] second_reg, second_next;
    logic               pair_reg, pair_next;
    logic               eop_reg, eop_next;
    logic               out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]   out_res_reg, out_res_next;
    logic               out_item_reg, out_item_next;
    logic               out_done_reg, out_done_next;
    logic [MOD_W-1:0]   n_eff;
    logic [MOD_W-1:0]   rem_step;

    always_comb begin
        if (modulus == '0) begin
            n_eff = MOD_W'(1);
        end else if (modulus > MaxMod) begin
            n_eff = MaxMod;
        end else begin
            n_eff = modulus;
        end
    end

    always_comb begin
        logic [MOD_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            r = {r[MOD_W-1:0], work_reg[DIV_W-DIV_BITS+i]};
            if (r >= {1'b0, n_eff}) begin
                r = r - {1'b0, n_eff};
            end
        end
        rem_step = r[MOD_W-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        second_next    = second_reg;
        pair_next      = pair_reg;
        eop_next       = eop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next   = out_res_reg;
        out_item_next  = out_item_reg;
        out_done_next  = out_done_reg;
        pop            = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!fifo_empty) begin
                    pop         = 1'b1;
                    work_next   = DIV_W'(job.v0);
                    second_next = job.v1;
                    pair_next   = job.pair;
                    eop_next    = job.eop;
                    rem_next    = '0;
                    step_next   = '0;
                    state_next  = BK_DIV;
                end
            end
            BK_DIV: begin
                rem_next  = rem_step;
                work_next = work_reg << DIV_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = rem_reg;
                    if (pair_reg) begin
                        out_item_next = 1'b0;
                        out_done_next = 1'b0;
                        work_next     = DIV_W'(second_reg);
                        pair_next     = 1'b0;
                        rem_next      = '0;
                        step_next     = '0;
                        state_next    = BK_DIV;
                    end else begin
                        out_item_next = 1'b1;
                        out_done_next = eop_reg;
                        state_next    = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        second_reg   <= second_next;
        pair_reg     <= pair_next;
        eop_reg      <= eop_next;
        out_res_reg  <= out_res_next;
        out_item_reg <= out_item_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);
    assign m_tuser  = out_item_reg;
    assign m_tlast  = out_done_reg;

endmodule

>>> src/packed_product_unpack_mod_core.sv
// Usage:
// Unpacks base-M packed product coefficients (M = 2^16 or 2^17) into residues
// modulo a small modulus. Input stream s_*: tdata holds packed_coeff, tuser the
// func code (0 pair, 1 final low digit, 2 carry flush, 3 ignored) and tlast
// marks the end of a product. Output stream m_*: tdata holds the residue,
// tuser[0] flags the last result of an input transfer, tlast the final
// residue of a product. Registers are written on cfg_wr_en: index 0 the
// modulus, index 1 the digit mode; write only while the block is idle.
// A job is taken from the queue in BK_IDLE, then the remainder unit (BK_DIV)
// retires 4 bits of the 20-bit work word per cycle, and BK_WAIT loads the
// residue into the output register; a pair transfer runs the unit twice,
// once per digit.
// The front end keeps the carry digit and hands jobs to the back end through
// a two-entry queue; s_tready drops when that queue is full. A stalled
// receiver holds the output register and the remainder unit waits on it.
// Reset clears the carry, the queue, the output valid and the registers
// (modulus 2, digit mode 0). Depends on ppu_pkg and the ppu_* modules.
module packed_product_unpack_mod_core import ppu_pkg::*; #(
    parameter int MAX_MODULUS = DEF_MAX_MODULUS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [MOD_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [49:0] packed_coeff
    input  logic [1:0]           s_tuser,   // [1:0] func
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [4:0] residue
    output logic [0:0]           m_tuser,   // [0] last_of_item
    output logic                 m_tlast
);

    logic [MOD_W-1:0] modulus_reg;
    logic             digit_mode_reg;
    logic             push, pop, fifo_full, fifo_empty;
    job_t             push_job, pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg    <= MODULUS_RESET;
            digit_mode_reg <= DIGIT_MODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODULUS:    modulus_reg    <= cfg_data;
                REG_DIGIT_MODE: digit_mode_reg <= cfg_data[0];
                default:        modulus_reg    <= modulus_reg;
            endcase
        end
    end

    ppu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .digit_mode (digit_mode_reg),
        .fifo_full  (fifo_full),
        .push       (push),
        .job        (push_job)
    );

    ppu_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    ppu_back #(
        .MAX_MODULUS (MAX_MODULUS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .modulus    (modulus_reg),
        .fifo_empty (fifo_empty),
        .job        (pop_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> src/ppu_checker.sv
// Port-level assertions for packed_product_unpack_mod_core, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ppu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    `PPU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")
    `PPU_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output changed")
    `PPU_ASSERT(a_res_range, m_tvalid |-> m_tdata[7:5] == 3'd0 && m_tdata[4:0] <= 5'd22, "residue out of range")
    `PPU_ASSERT(a_done_last, m_tvalid && m_tlast |-> m_tuser[0], "product end not on last result")

endmodule

bind packed_product_unpack_mod_core ppu_checker u_ppu_checker (.*);
